/* src/wdr_pkg.sv */
package wdr_pkg;

    // Operation codes carried by each input item.
    typedef enum logic [1:0] {
        OP_PIN       = 2'd0,
        OP_TICK      = 2'd1,
        OP_TAKE_CARD = 2'd2,
        OP_TAKE_PAD  = 2'd3
    } t_op;

    // Configuration register indexes.
    localparam logic [7:0] CFG_IDLE_LIMIT = 8'd0;
    localparam logic [7:0] CFG_CARD_EN    = 8'd1;
    localparam logic [7:0] CFG_PAD_EN     = 8'd2;
    localparam logic [7:0] CFG_COMBO      = 8'd3;

    // Frame geometry and counter limits.
    localparam int          CARD_BITS        = 26;
    localparam int          PAD_BITS         = 4;
    localparam int          CARD_DATA_BITS   = 24;
    localparam logic [5:0]  COUNT_MAX        = 6'd63;
    localparam logic [7:0]  IDLE_MAX         = 8'd255;
    localparam logic [7:0]  IDLE_LIMIT_RESET = 8'd10;

    // Configuration seen by the receiver core.
    typedef struct packed {
        logic [7:0] idle_limit;
        logic       card_en;
        logic       pad_en;
        logic       combo;
    } t_cfg;

    // One result item.
    typedef struct packed {
        logic                      card_ready;
        logic [CARD_DATA_BITS-1:0] card_value;
        logic                      pad_ready;
        logic [PAD_BITS-1:0]       pad_value;
    } t_result;

endpackage

/* src/wiegand_dual_receiver_unit.sv */
// Dual Wiegand receiver: one card reader channel and one keypad channel.
// Input items arrive on i_in_valid / o_in_ready and carry an operation code
// (pin event, idle tick, take card value, take keypad value) with the four
// line levels, which only a pin event uses. Every accepted item yields one
// result item on o_out_valid / i_out_ready holding both ready flags and both
// held values.
// Each result is registered and shown from the cycle after its item is taken.
// One item is taken every cycle unless the consumer stalls; the whole update
// runs in one combinational pass from receiver state into the result register.
// When the consumer stalls, o_in_ready stays high only in the cycle in which
// the waiting result is taken, so the result register is refilled at once.
// Configuration writes on i_cfg_valid / o_cfg_ready are taken in any cycle
// and are meant to be issued while no item is in flight.
// Synchronous reset clears the receiver state, empties the result register
// and loads the register reset values (idle limit 10, both channels enabled,
// combo mode off).
module wiegand_dual_receiver_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic        i_card_d0,
    input  logic        i_card_d1,
    input  logic        i_pad_d0,
    input  logic        i_pad_d1,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_card_ready,
    output logic [23:0] o_card_value,
    output logic        o_pad_ready,
    output logic [3:0]  o_pad_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    wdr_pkg::t_cfg    cfg;
    wdr_pkg::t_result result;
    wdr_pkg::t_result r_out;
    logic             r_out_valid;
    logic             in_accept;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    // Configuration registers.
    wdr_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Receiver state and per-item update.
    wdr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_op     (wdr_pkg::t_op'(i_op)),
        .i_lines  ({i_pad_d1, i_pad_d0, i_card_d1, i_card_d0}),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_card_ready = r_out.card_ready;
    assign o_card_value = r_out.card_value;
    assign o_pad_ready  = r_out.pad_ready;
    assign o_pad_value  = r_out.pad_value;

    // Every accepted item shows up as a result in the next cycle.
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_out_valid)
        else $error("accepted item produced no result");

    // A waiting result that is not taken blocks new items.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !in_accept)
        else $error("result overwritten before it was taken");

    // A result is dropped only by being taken.
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("result lost without a take");

endmodule

/* src/wdr_cfg_regs.sv */
module wdr_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [7:0]    i_cfg_index,
    input  logic [7:0]    i_cfg_data,
    output wdr_pkg::t_cfg o_cfg
);

    wdr_pkg::t_cfg r_cfg;

    // Writes are always taken; unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register file with its reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idle_limit <= wdr_pkg::IDLE_LIMIT_RESET;
            r_cfg.card_en    <= 1'b1;
            r_cfg.pad_en     <= 1'b1;
            r_cfg.combo      <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                wdr_pkg::CFG_IDLE_LIMIT: r_cfg.idle_limit <= i_cfg_data;
                wdr_pkg::CFG_CARD_EN:    r_cfg.card_en    <= i_cfg_data[0];
                wdr_pkg::CFG_PAD_EN:     r_cfg.pad_en     <= i_cfg_data[0];
                wdr_pkg::CFG_COMBO:      r_cfg.combo      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

/* src/wdr_core.sv */
module wdr_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  wdr_pkg::t_op     i_op,
    input  logic [3:0]       i_lines,
    input  wdr_pkg::t_cfg    i_cfg,
    output wdr_pkg::t_result o_result
);

    logic [3:0]  r_last_lines, n_last_lines;
    logic [25:0] r_card_shift, n_card_shift;
    logic [5:0]  r_card_count, n_card_count;
    logic [3:0]  r_pad_shift,  n_pad_shift;
    logic [5:0]  r_pad_count,  n_pad_count;
    logic [7:0]  r_idle_count, n_idle_count;
    logic [23:0] r_card_held,  n_card_held;
    logic [3:0]  r_pad_held,   n_pad_held;
    logic        r_card_flag,  n_card_flag;
    logic        r_pad_flag,   n_pad_flag;

    logic [3:0]  fell;
    logic [3:0]  changed;
    logic [3:0]  watched;
    logic        close;
    logic        card_rep;
    logic        pad_rep;

    function automatic logic [5:0] count_up(input logic [5:0] c);
        return (c < wdr_pkg::COUNT_MAX) ? c + 6'd1 : wdr_pkg::COUNT_MAX;
    endfunction

    assign fell    = r_last_lines & ~i_lines;
    assign changed = r_last_lines ^ i_lines;
    assign watched = {{2{i_cfg.pad_en}}, {2{i_cfg.card_en}}};
    assign close   = r_idle_count > i_cfg.idle_limit;

    // Next state for one item.
    always_comb begin
        n_last_lines = r_last_lines;
        n_card_shift = r_card_shift;
        n_card_count = r_card_count;
        n_pad_shift  = r_pad_shift;
        n_pad_count  = r_pad_count;
        n_idle_count = r_idle_count;
        n_card_held  = r_card_held;
        n_pad_held   = r_pad_held;
        n_card_flag  = r_card_flag;
        n_pad_flag   = r_pad_flag;
        card_rep     = 1'b0;
        pad_rep      = 1'b0;

        case (i_op)
            wdr_pkg::OP_PIN: begin
                // A falling edge shifts in a bit; D1 wins when both fall.
                if (i_cfg.card_en && (fell[1:0] != 2'b00)) begin
                    n_card_shift = {r_card_shift[24:0], fell[1]};
                    n_card_count = count_up(r_card_count);
                end
                if (i_cfg.pad_en && (fell[3:2] != 2'b00)) begin
                    n_pad_shift = {r_pad_shift[2:0], fell[3]};
                    n_pad_count = count_up(r_pad_count);
                end
                if ((changed & watched) != 4'd0) begin
                    n_idle_count = '0;
                end
                n_last_lines = i_lines;
            end
            wdr_pkg::OP_TICK: begin
                if (r_idle_count != wdr_pkg::IDLE_MAX) begin
                    n_idle_count = r_idle_count + 8'd1;
                end
                // Frame close: the keypad digit is applied last so it wins.
                if (close && i_cfg.card_en) begin
                    if (i_cfg.combo && (r_card_count == 6'(wdr_pkg::PAD_BITS))) begin
                        n_pad_held = r_card_shift[3:0];
                        n_pad_flag = 1'b1;
                    end else if (r_card_count == 6'(wdr_pkg::CARD_BITS)) begin
                        n_card_held = r_card_shift[24:1];
                        n_card_flag = 1'b1;
                    end
                    n_card_shift = '0;
                    n_card_count = '0;
                end
                if (close && i_cfg.pad_en) begin
                    if (r_pad_count == 6'(wdr_pkg::PAD_BITS)) begin
                        n_pad_held = r_pad_shift;
                        n_pad_flag = 1'b1;
                    end
                    n_pad_shift = '0;
                    n_pad_count = '0;
                end
            end
            default: ;
        endcase

        // A take reports its flag as it stood before being cleared.
        card_rep = n_card_flag;
        pad_rep  = n_pad_flag;
        if (i_op == wdr_pkg::OP_TAKE_CARD) begin
            n_card_flag = 1'b0;
        end else if (i_op == wdr_pkg::OP_TAKE_PAD) begin
            n_pad_flag = 1'b0;
        end
    end

    assign o_result.card_ready = card_rep;
    assign o_result.card_value = n_card_held;
    assign o_result.pad_ready  = pad_rep;
    assign o_result.pad_value  = n_pad_held;

    // Receiver state, updated once per accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_lines <= '0;
            r_card_shift <= '0;
            r_card_count <= '0;
            r_pad_shift  <= '0;
            r_pad_count  <= '0;
            r_idle_count <= '0;
            r_card_held  <= '0;
            r_pad_held   <= '0;
            r_card_flag  <= 1'b0;
            r_pad_flag   <= 1'b0;
        end else if (i_accept) begin
            r_last_lines <= n_last_lines;
            r_card_shift <= n_card_shift;
            r_card_count <= n_card_count;
            r_pad_shift  <= n_pad_shift;
            r_pad_count  <= n_pad_count;
            r_idle_count <= n_idle_count;
            r_card_held  <= n_card_held;
            r_pad_held   <= n_pad_held;
            r_card_flag  <= n_card_flag;
            r_pad_flag   <= n_pad_flag;
        end
    end

    // A card take always leaves the card flag clear.
    a_take_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_op == wdr_pkg::OP_TAKE_CARD) |=> !r_card_flag)
        else $error("card flag still set after take");

    // A closing tick on the enabled card channel empties its frame.
    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_op == wdr_pkg::OP_TICK && close && i_cfg.card_en)
        |=> (r_card_count == 6'd0))
        else $error("card frame not cleared on close");

    // The pad shift register only moves on a pin event or a close.
    a_pad_shift_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (i_op == wdr_pkg::OP_TAKE_CARD || i_op == wdr_pkg::OP_TAKE_PAD))
        |=> $stable(r_pad_shift))
        else $error("pad shift register changed on a take");

endmodule

/* tb/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 150;
    localparam int CYCLE_LIMIT = 400000;

    logic              i_clk;
    logic              i_rst_n;
    logic              in_valid;
    logic              o_in_ready;
    wdr_pkg::t_op      in_op;
    logic [3:0]        in_lines;
    logic              o_out_valid;
    logic              out_ready;
    logic              o_card_ready;
    logic [23:0]       o_card_value;
    logic              o_pad_ready;
    logic [3:0]        o_pad_value;
    logic              cfg_valid;
    logic              o_cfg_ready;
    logic [7:0]        cfg_index;
    logic [7:0]        cfg_data;

    wiegand_dual_receiver_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (in_op),
        .i_card_d0    (in_lines[0]),
        .i_card_d1    (in_lines[1]),
        .i_pad_d0     (in_lines[2]),
        .i_pad_d1     (in_lines[3]),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_card_ready (o_card_ready),
        .o_card_value (o_card_value),
        .o_pad_ready  (o_pad_ready),
        .o_pad_value  (o_pad_value),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    // Predicted receiver state and register copy.
    wdr_pkg::t_cfg     cfg_now;
    logic [3:0]        last_levels;
    logic [25:0]       card_frame;
    logic [5:0]        card_bits;
    logic [3:0]        pad_frame;
    logic [5:0]        pad_bits;
    logic [7:0]        idle_ticks;
    logic [23:0]       card_word;
    logic [3:0]        pad_digit;
    logic              card_waiting;
    logic              pad_waiting;

    wdr_pkg::t_result  pending_results[$];
    int                fail_count;
    int                sent_items;
    int                cycle_count;
    bit                gaps_on;
    bit                stalls_on;
    bit                hold_req;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run guard against a hung handshake.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL wiegand_dual_receiver_unit");
            $finish;
        end
    end

    // Works out the result of one accepted item and updates the predicted state.
    task automatic predict_result(input wdr_pkg::t_op op, input logic [3:0] lines);
        logic [3:0]       fell;
        logic [3:0]       changed;
        logic [3:0]       watched;
        logic             closing;
        wdr_pkg::t_result res;
        case (op)
            wdr_pkg::OP_PIN: begin
                fell = last_levels & ~lines;
                changed = last_levels ^ lines;
                watched = 4'b0000;
                if (cfg_now.card_en) begin
                    watched[1:0] = 2'b11;
                    if (fell[1:0] != 2'b00) begin
                        card_frame = {card_frame[24:0], fell[1]};
                        if (card_bits != wdr_pkg::COUNT_MAX) card_bits = card_bits + 6'd1;
                    end
                end
                if (cfg_now.pad_en) begin
                    watched[3:2] = 2'b11;
                    if (fell[3:2] != 2'b00) begin
                        pad_frame = {pad_frame[2:0], fell[3]};
                        if (pad_bits != wdr_pkg::COUNT_MAX) pad_bits = pad_bits + 6'd1;
                    end
                end
                if ((changed & watched) != 4'b0000) idle_ticks = 8'd0;
                last_levels = lines;
            end
            wdr_pkg::OP_TICK: begin
                // The close decision uses the count before this tick.
                closing = idle_ticks > cfg_now.idle_limit;
                if (idle_ticks != wdr_pkg::IDLE_MAX) idle_ticks = idle_ticks + 8'd1;
                if (closing) begin
                    if (cfg_now.card_en) begin
                        if (cfg_now.combo && card_bits == 6'(wdr_pkg::PAD_BITS)) begin
                            pad_digit = card_frame[3:0];
                            pad_waiting = 1'b1;
                        end else if (card_bits == 6'(wdr_pkg::CARD_BITS)) begin
                            card_word = card_frame[24:1];
                            card_waiting = 1'b1;
                        end
                        card_frame = '0;
                        card_bits = '0;
                    end
                    // The keypad digit overrides a combo digit from the card lines.
                    if (cfg_now.pad_en) begin
                        if (pad_bits == 6'(wdr_pkg::PAD_BITS)) begin
                            pad_digit = pad_frame;
                            pad_waiting = 1'b1;
                        end
                        pad_frame = '0;
                        pad_bits = '0;
                    end
                end
            end
            default: ;
        endcase
        res.card_ready = card_waiting;
        res.card_value = card_word;
        res.pad_ready = pad_waiting;
        res.pad_value = pad_digit;
        if (op == wdr_pkg::OP_TAKE_CARD) card_waiting = 1'b0;
        else if (op == wdr_pkg::OP_TAKE_PAD) pad_waiting = 1'b0;
        pending_results.push_back(res);
    endtask

    // Offers one item, idling at random first, and predicts it once accepted.
    task automatic send_item(input wdr_pkg::t_op op, input logic [3:0] lines);
        @(negedge i_clk);
        while (gaps_on && $urandom_range(0, 99) < 14) begin
            in_valid <= 1'b0;
            in_op <= wdr_pkg::t_op'($urandom_range(0, 3));
            in_lines <= 4'($urandom_range(0, 15));
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_op <= op;
        in_lines <= lines;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_result(op, lines);
        sent_items++;
    endtask

    // Lowers valid and waits until every predicted result has been checked.
    task automatic drain;
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // Writes one register; only called once the block has drained.
    task automatic write_reg(input logic [7:0] idx, input logic [7:0] data);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            wdr_pkg::CFG_IDLE_LIMIT: cfg_now.idle_limit = data;
            wdr_pkg::CFG_CARD_EN:    cfg_now.card_en = data[0];
            wdr_pkg::CFG_PAD_EN:     cfg_now.pad_en = data[0];
            wdr_pkg::CFG_COMBO:      cfg_now.combo = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Loads a full setting, with random upper bits on the one-bit registers.
    task automatic apply_setting(input logic [7:0] limit, input bit card_on,
                                 input bit pad_on, input bit combo_on);
        logic [6:0] junk;
        drain();
        write_reg(wdr_pkg::CFG_IDLE_LIMIT, limit);
        junk = 7'($urandom_range(0, 127));
        write_reg(wdr_pkg::CFG_CARD_EN, {junk, card_on});
        junk = 7'($urandom_range(0, 127));
        write_reg(wdr_pkg::CFG_PAD_EN, {junk, pad_on});
        junk = 7'($urandom_range(0, 127));
        write_reg(wdr_pkg::CFG_COMBO, {junk, combo_on});
    endtask

    // Picks which line of a pair falls: D1 for a one, D0 for a zero, rarely both.
    function automatic logic [1:0] pick_fall();
        if ($urandom_range(0, 15) == 0) return 2'b11;
        return $urandom_range(0, 1) ? 2'b10 : 2'b01;
    endfunction

    // One bit pulse: the chosen lines drop and all lines return high.
    task automatic send_pulse(input logic [3:0] low_mask);
        send_item(wdr_pkg::OP_PIN, ~low_mask);
        send_item(wdr_pkg::OP_PIN, 4'hF);
    endtask

    // Sends a card frame and a keypad frame, sometimes with their bits together.
    task automatic send_frames(input int card_n, input int pad_n);
        int n;
        logic [1:0] card_fall;
        logic [1:0] pad_fall;
        n = (card_n > pad_n) ? card_n : pad_n;
        send_item(wdr_pkg::OP_PIN, 4'hF);
        for (int i = 0; i < n; i++) begin
            card_fall = (i < card_n) ? pick_fall() : 2'b00;
            pad_fall = (i < pad_n) ? pick_fall() : 2'b00;
            if ($urandom_range(0, 1)) begin
                send_pulse({pad_fall, card_fall});
            end else begin
                if (card_fall != 2'b00) send_pulse({2'b00, card_fall});
                if (pad_fall != 2'b00) send_pulse({pad_fall, 2'b00});
            end
        end
    endtask

    // Ticks until the frames close, with takes scattered around.
    task automatic close_frames(input int extra);
        int ticks;
        ticks = (cfg_now.idle_limit == wdr_pkg::IDLE_MAX) ? 3
                                                           : int'(cfg_now.idle_limit) + 2;
        ticks = ticks + extra;
        for (int i = 0; i < ticks; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1)) send_item(wdr_pkg::OP_TAKE_CARD, 4'hF);
                else send_item(wdr_pkg::OP_TAKE_PAD, 4'hF);
            end
            send_item(wdr_pkg::OP_TICK, 4'($urandom_range(0, 15)));
        end
        if ($urandom_range(0, 9) < 7)
            send_item(wdr_pkg::OP_TAKE_CARD, 4'($urandom_range(0, 15)));
        if ($urandom_range(0, 9) < 7)
            send_item(wdr_pkg::OP_TAKE_PAD, 4'($urandom_range(0, 15)));
        if ($urandom_range(0, 9) == 0) send_item(wdr_pkg::OP_TAKE_PAD, 4'hF);
    endtask

    // Random items of any kind.
    task automatic send_noise(input int n);
        for (int i = 0; i < n; i++)
            send_item(wdr_pkg::t_op'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
    endtask

    // Mostly well-formed frames with random data, some broken ones and noise.
    task automatic run_phase(input int budget);
        int first;
        int pick;
        int card_n;
        int pad_n;
        first = sent_items;
        while (sent_items - first < budget) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                pick = $urandom_range(0, 19);
                if (pick < 11) card_n = wdr_pkg::CARD_BITS;
                else if (pick < 14) card_n = wdr_pkg::PAD_BITS;
                else if (pick < 16) card_n = 0;
                else if (pick < 18) card_n = $urandom_range(1, 40);
                else if (pick == 18) card_n = $urandom_range(0, 1) ? 25 : 27;
                else card_n = 70;
                pick = $urandom_range(0, 19);
                if (pick < 12) pad_n = wdr_pkg::PAD_BITS;
                else if (pick < 15) pad_n = 0;
                else if (pick < 17) pad_n = $urandom_range(0, 1) ? 3 : 5;
                else if (pick < 19) pad_n = $urandom_range(1, 12);
                else pad_n = 70;
                send_frames(card_n, pad_n);
                close_frames($urandom_range(0, 2));
            end else if (pick < 9) begin
                send_noise($urandom_range(1, 8));
            end else begin
                // Broken frame: a few bits, then ticks that may or may not close it.
                send_frames($urandom_range(1, 30), $urandom_range(1, 6));
                send_noise($urandom_range(0, 3));
                for (int i = 0; i < $urandom_range(1, 4); i++)
                    send_item(wdr_pkg::OP_TICK, 4'hF);
            end
        end
    endtask

    task automatic test_reset_state;
        send_item(wdr_pkg::OP_TAKE_CARD, 4'h0);
        send_item(wdr_pkg::OP_TAKE_PAD, 4'hF);
    endtask

    // A keypad digit built by hand, one edge with all four lines falling together.
    task automatic test_directed_frames;
        apply_setting(8'd0, 1'b1, 1'b1, 1'b0);
        send_item(wdr_pkg::OP_PIN, 4'hF);
        send_item(wdr_pkg::OP_PIN, 4'h0);
        send_item(wdr_pkg::OP_PIN, 4'hF);
        send_item(wdr_pkg::OP_PIN, 4'b1011);
        send_item(wdr_pkg::OP_PIN, 4'hF);
        send_item(wdr_pkg::OP_PIN, 4'b0111);
        send_item(wdr_pkg::OP_PIN, 4'hF);
        send_item(wdr_pkg::OP_PIN, 4'b0111);
        send_item(wdr_pkg::OP_TICK, 4'h0);
        send_item(wdr_pkg::OP_TICK, 4'hF);
        send_item(wdr_pkg::OP_TICK, 4'h5);
        send_item(wdr_pkg::OP_TAKE_PAD, 4'hA);
        send_item(wdr_pkg::OP_TAKE_PAD, 4'h0);
        send_item(wdr_pkg::OP_TAKE_CARD, 4'hF);
    endtask

    // Writes to indexes past the last register must change nothing.
    task automatic test_register_writes;
        drain();
        write_reg(8'd4, 8'hFF);
        write_reg(8'hFF, 8'h00);
        write_reg(8'($urandom_range(5, 254)), 8'($urandom_range(0, 255)));
        write_reg(wdr_pkg::CFG_CARD_EN, 8'hFE);
        write_reg(wdr_pkg::CFG_PAD_EN, 8'hFF);
        send_frames(wdr_pkg::CARD_BITS, wdr_pkg::PAD_BITS);
        close_frames(0);
        apply_setting(8'hFF, 1'b1, 1'b1, 1'b1);
        write_reg(wdr_pkg::CFG_IDLE_LIMIT, 8'h00);
        send_noise(6);
    endtask

    task automatic test_random_phases;
        apply_setting(8'd0, 1'b1, 1'b1, 1'b0);
        run_phase(120);
        apply_setting(8'd3, 1'b1, 1'b1, 1'b1);
        run_phase(120);
        apply_setting(8'd1, 1'b0, 1'b1, 1'b1);
        run_phase(80);
        apply_setting(8'd2, 1'b1, 1'b0, 1'b1);
        run_phase(80);
        apply_setting(8'd254, 1'b1, 1'b1, 1'b0);
        run_phase(100);
        apply_setting(8'd6, 1'b0, 1'b0, 1'b0);
        run_phase(40);
        repeat (3) begin
            apply_setting(8'($urandom_range(0, 8)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            run_phase(60);
        end
    endtask

    // With the highest limit nothing closes, and the idle count sticks at its top.
    task automatic test_idle_saturation;
        apply_setting(8'd255, 1'b1, 1'b1, 1'b1);
        send_frames(wdr_pkg::PAD_BITS, wdr_pkg::PAD_BITS);
        for (int i = 0; i < 300; i++)
            send_item(wdr_pkg::OP_TICK, 4'($urandom_range(0, 15)));
        send_item(wdr_pkg::OP_TAKE_PAD, 4'hF);
        apply_setting(8'd254, 1'b1, 1'b1, 1'b1);
        send_item(wdr_pkg::OP_TICK, 4'hF);
        send_item(wdr_pkg::OP_TAKE_PAD, 4'hF);
        send_item(wdr_pkg::OP_TAKE_CARD, 4'hF);
    endtask

    // A stretch with neither side idling.
    task automatic test_back_to_back;
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        apply_setting(8'd1, 1'b1, 1'b1, 1'b1);
        run_phase(100);
        gaps_on = 1'b1;
        stalls_on = 1'b1;
    endtask

    // The consumer holds off while items keep coming, so the input stalls.
    task automatic test_backpressure;
        apply_setting(8'd0, 1'b1, 1'b1, 1'b0);
        hold_req = 1'b1;
        send_noise(40);
        wait (!hold_req);
        run_phase(60);
    endtask

    // Consumer side: random stalls and one long hold-off on request.
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            out_ready <= !(stalls_on && $urandom_range(0, 99) < 14);
        end
    end

    task automatic report_field(input string field, input logic [23:0] want,
                                input logic [23:0] got);
        fail_count++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endtask

    // Each result item is checked against the oldest prediction.
    always @(posedge i_clk) begin
        wdr_pkg::t_result want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result item, expected none, actual %h %h %h %h",
                         $time, o_card_ready, o_card_value, o_pad_ready, o_pad_value);
            end else begin
                want = pending_results.pop_front();
                if (o_card_ready !== want.card_ready)
                    report_field("card_ready", 24'(want.card_ready), 24'(o_card_ready));
                if (o_card_value !== want.card_value)
                    report_field("card_value", want.card_value, o_card_value);
                if (o_pad_ready !== want.pad_ready)
                    report_field("pad_ready", 24'(want.pad_ready), 24'(o_pad_ready));
                if (o_pad_value !== want.pad_value)
                    report_field("pad_value", 24'(want.pad_value), 24'(o_pad_value));
            end
        end
    end

    // Test sequence.
    initial begin
        in_valid = 1'b0;
        in_op = wdr_pkg::OP_PIN;
        in_lines = 4'h0;
        cfg_valid = 1'b0;
        cfg_index = 8'd0;
        cfg_data = 8'd0;
        i_rst_n = 1'b0;
        fail_count = 0;
        sent_items = 0;
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        hold_req = 1'b0;
        cfg_now = '{idle_limit: wdr_pkg::IDLE_LIMIT_RESET, card_en: 1'b1, pad_en: 1'b1,
                    combo: 1'b0};
        last_levels = '0;
        card_frame = '0;
        card_bits = '0;
        pad_frame = '0;
        pad_bits = '0;
        idle_ticks = '0;
        card_word = '0;
        pad_digit = '0;
        card_waiting = 1'b0;
        pad_waiting = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_directed_frames();
        test_register_writes();
        test_random_phases();
        test_idle_saturation();
        test_back_to_back();
        test_backpressure();

        drain();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("PASS wiegand_dual_receiver_unit");
        else
            $display("FAIL wiegand_dual_receiver_unit");
        $finish;
    end

endmodule

/* sim.f */
src/wdr_pkg.sv
src/wdr_cfg_regs.sv
src/wdr_core.sv
src/wiegand_dual_receiver_unit.sv
tb/tb.sv
